[rtl/core/ffha_pkg.sv]
`timescale 1ns / 1ps

package ffha_pkg;

  // heap geometry
  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 12;
  localparam int WORD_BYTES   = 4;
  localparam int DEPTH        = HEAP_BYTES / WORD_BYTES;

  // field and datapath widths
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int OFF_W  = $clog2(HEAP_BYTES) + 1;
  localparam int SIZE_W = $clog2(HEAP_BYTES);
  localparam int REQ_W  = 13;
  localparam int BOFF_W = 12;
  localparam int ALU_W  = REQ_W + 1;

  // header entry, one per 4-byte word of the heap
  typedef struct packed {
    logic              start;
    logic              free;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  // shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_ADD3,
    ALU_SUB3,
    ALU_GE
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             ge;
  } alu_rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_FIT,
    ST_A_STEP,
    ST_A_REM,
    ST_A_SPLIT,
    ST_A_TAKE,
    ST_F_RD,
    ST_F_MARK,
    ST_M_RD,
    ST_M_CUR,
    ST_M_NXT,
    ST_M_EVAL,
    ST_M_CLR,
    ST_FIN
  } st_t;

endpackage

[rtl/core/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// An allocate walks the block headers from the heap start and may split the block it takes;
// a free marks its block, then walks the blocks from the heap start, merging free neighbors.
// One command at a time: a new command is taken only after the walk over the header memory
// (one read port, one write port, one shared adder) ends and its result is loaded.
// Reset: synchronous active-low; afterwards a clearing pass over all 1024 header
// memory words runs before the first input transfer is taken.

module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes[12:0], block_offset[24:13], zero pad
  input  logic [0:0]  in_tuser,   // command[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // payload_offset[11:0], zero pad
  output logic [0:0]  out_tuser   // granted[0]
);

  localparam logic [ALU_W-1:0] HDR_C   = ALU_W'(HEADER_BYTES);
  localparam logic [ALU_W-1:0] ROUND_C = ALU_W'(WORD_BYTES - 1);
  localparam logic [ALU_W-1:0] SPLIT_C = ALU_W'(WORD_BYTES);
  localparam logic [ALU_W-1:0] HEAP_C  = ALU_W'(HEAP_BYTES);
  localparam int               WB_W    = $clog2(WORD_BYTES);

  // header memory
  hdr_t mem [DEPTH];
  hdr_t rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  hdr_t             wr_data;

  // sequencer and datapath registers
  st_t st_r, st_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [OFF_W-1:0]  cur_r, cur_nxt;
  logic [OFF_W-1:0]  nxt_r, nxt_nxt;
  logic [ALU_W-1:0]  need_r, need_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              free_r, free_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [BOFF_W-1:0] res_off_r, res_off_nxt;
  logic              res_grant_r, res_grant_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BOFF_W-1:0] out_off_r, out_off_nxt;
  logic              out_grant_r, out_grant_nxt;

  logic              in_xfer;
  logic              cmd_free;
  logic [REQ_W-1:0]  req_bytes;
  logic [BOFF_W-1:0] blk_off;
  logic              slot_free;
  logic              rem_split;
  logic              free_bad;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  ffha_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_tready = (st_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cmd_free  = in_tuser[0];
  assign req_bytes = in_tdata[REQ_W-1:0];
  assign blk_off   = in_tdata[REQ_W+BOFF_W-1:REQ_W];
  assign slot_free = !out_valid_r || out_tready;

  // remainder after the cut is a real block only when above one word
  assign rem_split = !alu_rsp.res[ALU_W-1] && (alu_rsp.res > SPLIT_C);
  // header position below zero or off the word grid is never a block start
  assign free_bad  = alu_rsp.res[ALU_W-1] || (alu_rsp.res[WB_W-1:0] != '0);

  // shared unit operand selection
  always_comb begin
    alu_req = '{op: ALU_ADD3, a: '0, b: '0, c: '0};
    case (st_r)
      ST_IDLE: begin
        if (cmd_free) begin
          alu_req = '{op: ALU_SUB3, a: ALU_W'(blk_off), b: HDR_C, c: '0};
        end else begin
          alu_req = '{op: ALU_ADD3, a: ALU_W'(req_bytes), b: ROUND_C, c: '0};
        end
      end
      ST_A_FIT:   alu_req = '{op: ALU_GE, a: ALU_W'(rd_data_r.size), b: need_r, c: '0};
      ST_A_STEP:  alu_req = '{op: ALU_ADD3, a: ALU_W'(cur_r), b: ALU_W'(size_r), c: HDR_C};
      ST_A_REM:   alu_req = '{op: ALU_SUB3, a: ALU_W'(size_r), b: need_r, c: HDR_C};
      ST_A_SPLIT: alu_req = '{op: ALU_ADD3, a: ALU_W'(cur_r), b: need_r, c: HDR_C};
      ST_A_TAKE:  alu_req = '{op: ALU_ADD3, a: ALU_W'(cur_r), b: '0, c: HDR_C};
      ST_M_NXT:   alu_req = '{op: ALU_ADD3, a: ALU_W'(cur_r), b: ALU_W'(size_r), c: HDR_C};
      ST_M_EVAL: begin
        alu_req = '{op: ALU_ADD3, a: ALU_W'(size_r), b: ALU_W'(rd_data_r.size), c: HDR_C};
      end
      default: alu_req = '{op: ALU_ADD3, a: '0, b: '0, c: '0};
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: begin
        if (clr_idx_r == IDX_W'(DEPTH - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (cmd_free) begin
            st_nxt = free_bad ? ST_FIN : ST_F_RD;
          end else begin
            st_nxt = (req_bytes == '0) ? ST_FIN : ST_A_RD;
          end
        end
      end
      ST_A_RD:    st_nxt = (ALU_W'(cur_r) >= HEAP_C) ? ST_FIN : ST_A_FIT;
      ST_A_FIT: begin
        if (!rd_data_r.start) begin
          st_nxt = ST_FIN;
        end else if (rd_data_r.free && alu_rsp.ge) begin
          st_nxt = ST_A_REM;
        end else begin
          st_nxt = ST_A_STEP;
        end
      end
      ST_A_STEP:  st_nxt = ST_A_RD;
      ST_A_REM:   st_nxt = rem_split ? ST_A_SPLIT : ST_A_TAKE;
      ST_A_SPLIT: st_nxt = ST_A_TAKE;
      ST_A_TAKE:  st_nxt = ST_FIN;
      ST_F_RD:    st_nxt = ST_F_MARK;
      ST_F_MARK:  st_nxt = rd_data_r.start ? ST_M_RD : ST_FIN;
      ST_M_RD:    st_nxt = ST_M_CUR;
      ST_M_CUR:   st_nxt = rd_data_r.start ? ST_M_NXT : ST_FIN;
      ST_M_NXT:   st_nxt = (alu_rsp.res >= HEAP_C) ? ST_FIN : ST_M_EVAL;
      ST_M_EVAL: begin
        if (!rd_data_r.start) begin
          st_nxt = ST_FIN;
        end else if (free_r && rd_data_r.free) begin
          st_nxt = ST_M_CLR;
        end else begin
          st_nxt = ST_M_NXT;
        end
      end
      ST_M_CLR:   st_nxt = ST_M_NXT;
      ST_FIN:     st_nxt = slot_free ? ST_IDLE : ST_FIN;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    need_nxt      = need_r;
    size_nxt      = size_r;
    free_nxt      = free_r;
    rem_nxt       = rem_r;
    res_off_nxt   = res_off_r;
    res_grant_nxt = res_grant_r;
    out_off_nxt   = out_off_r;
    out_grant_nxt = out_grant_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_addr       = cur_r[WB_W+IDX_W-1:WB_W];
    wr_en         = 1'b0;
    wr_addr       = cur_r[WB_W+IDX_W-1:WB_W];
    wr_data       = '{start: 1'b0, free: 1'b0, size: '0};

    case (st_r)
      ST_CLEAR: begin
        // sweep the memory; word 0 gets the single heap-wide free block
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == '0) begin
          wr_data = '{start: 1'b1, free: 1'b1,
                      size: SIZE_W'(HEAP_BYTES - HEADER_BYTES)};
        end
      end
      ST_IDLE: begin
        res_off_nxt   = '0;
        res_grant_nxt = 1'b0;
        if (cmd_free) begin
          cur_nxt = alu_rsp.res[OFF_W-1:0];
        end else begin
          need_nxt = {alu_rsp.res[ALU_W-1:WB_W], {WB_W{1'b0}}};
          cur_nxt  = '0;
        end
      end
      ST_A_FIT: begin
        size_nxt = rd_data_r.size;
      end
      ST_A_STEP: begin
        cur_nxt = alu_rsp.res[OFF_W-1:0];
      end
      ST_A_REM: begin
        rem_nxt = alu_rsp.res[SIZE_W-1:0];
      end
      ST_A_SPLIT: begin
        wr_en    = 1'b1;
        wr_addr  = alu_rsp.res[WB_W+IDX_W-1:WB_W];
        wr_data  = '{start: 1'b1, free: 1'b1, size: rem_r};
        size_nxt = need_r[SIZE_W-1:0];
      end
      ST_A_TAKE: begin
        wr_en         = 1'b1;
        wr_data       = '{start: 1'b1, free: 1'b0, size: size_r};
        res_off_nxt   = alu_rsp.res[BOFF_W-1:0];
        res_grant_nxt = 1'b1;
      end
      ST_F_MARK: begin
        wr_en   = rd_data_r.start;
        wr_data = '{start: 1'b1, free: 1'b1, size: rd_data_r.size};
        cur_nxt = '0;
      end
      ST_M_CUR: begin
        size_nxt = rd_data_r.size;
        free_nxt = rd_data_r.free;
      end
      ST_M_NXT: begin
        nxt_nxt = alu_rsp.res[OFF_W-1:0];
        rd_addr = alu_rsp.res[WB_W+IDX_W-1:WB_W];
      end
      ST_M_EVAL: begin
        if (free_r && rd_data_r.free) begin
          // absorb the neighbor into the current block
          wr_en    = rd_data_r.start;
          wr_data  = '{start: 1'b1, free: 1'b1, size: alu_rsp.res[SIZE_W-1:0]};
          size_nxt = alu_rsp.res[SIZE_W-1:0];
        end else begin
          cur_nxt  = nxt_r;
          size_nxt = rd_data_r.size;
          free_nxt = rd_data_r.free;
        end
      end
      ST_M_CLR: begin
        wr_en   = 1'b1;
        wr_addr = nxt_r[WB_W+IDX_W-1:WB_W];
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = res_off_r;
          out_grant_nxt = res_grant_r;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // header memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    nxt_r       <= nxt_nxt;
    need_r      <= need_nxt;
    size_r      <= size_nxt;
    free_r      <= free_nxt;
    rem_r       <= rem_nxt;
    res_off_r   <= res_off_nxt;
    res_grant_r <= res_grant_nxt;
    out_off_r   <= out_off_nxt;
    out_grant_r <= out_grant_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - BOFF_W){1'b0}}, out_off_r};
  assign out_tuser  = out_grant_r;

  // a granted offset sits past a header on the word grid
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[1:0] == 2'b00) && (out_tdata[11:0] >= 12'(HEADER_BYTES)))
    else $error("granted offset off grid or inside first header");

  // a refused or free result carries no offset
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[11:0] == '0))
    else $error("non-granted result with nonzero offset");

  // no header write while waiting for a command or for the result slot
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE || st_r == ST_FIN) |-> !wr_en)
    else $error("header write outside a walk");

  // a new command only starts once the result of the last one is loaded
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN) && !slot_free |=> (st_r == ST_FIN) && !in_tready)
    else $error("sequencer left result stage with slot busy");

endmodule

[rtl/core/ffha_alu.sv]
`timescale 1ns / 1ps

module ffha_alu
  import ffha_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  // one three-input adder/subtractor and one magnitude compare
  always_comb begin
    rsp.ge  = (req.a >= req.b);
    rsp.res = '0;
    case (req.op)
      ALU_ADD3: rsp.res = req.a + req.b + req.c;
      ALU_SUB3: rsp.res = req.a - req.b - req.c;
      ALU_GE:   rsp.res = '0;
      default:  rsp.res = '0;
    endcase
  end

endmodule
